### rtl/core/cgen_pkg.sv
// -----------------------------------------------------------------------------
// cgen_pkg
// Shared widths, column codes and the memory control struct of the
// Chebyshev coefficient generator.
// -----------------------------------------------------------------------------
package cgen_pkg;

   localparam int DEGREE_W       = 6;
   localparam int POWER_W        = 6;
   localparam int COEF_W         = 48;
   localparam int MAX_DEGREE_DEF = 32;
   localparam int NUM_COLS       = 3;

   typedef logic [1:0] col_type;

   // column roles after reset and at every item start
   localparam col_type COL_NEXT_RST = 2'd0;
   localparam col_type COL_CUR_RST  = 2'd1;
   localparam col_type COL_PREV_RST = 2'd2;

   typedef struct packed {
      logic    rd_en_a;
      logic    rd_en_b;
      logic    wr_en;
      col_type col_a;
      col_type col_b;
      col_type col_w;
   } mem_ctl_type;

endpackage

### rtl/core/cgen_chan_if.sv
// -----------------------------------------------------------------------------
// cgen channel interfaces
// Valid/ready channels for degree requests and coefficient responses.
// -----------------------------------------------------------------------------
interface cgen_req_if import cgen_pkg::*;;
   logic                valid;
   logic                ready;
   logic [DEGREE_W-1:0] degree;

   modport source (output valid, output degree, input ready);
   modport sink   (input valid, input degree, output ready);
endinterface

interface cgen_rsp_if import cgen_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic [POWER_W-1:0]       power;
   logic signed [COEF_W-1:0] coefficient;
   logic                     last;

   modport source (output valid, output power, output coefficient, output last, input ready);
   modport sink   (input valid, input power, input coefficient, input last, output ready);
endinterface

### rtl/core/cgen_coef_mem.sv
// -----------------------------------------------------------------------------
// cgen_coef_mem
// Three coefficient columns, one write port and two registered read ports.
// -----------------------------------------------------------------------------
module cgen_coef_mem import cgen_pkg::*; #(
   parameter int  MAX_DEGREE = MAX_DEGREE_DEF,
   localparam int Rows       = MAX_DEGREE + 1,
   localparam int RowW       = $clog2(Rows)
) (
   input  logic              clock,
   input  mem_ctl_type       mem_ctl,
   input  logic [RowW-1:0]   rd_row_a,
   input  logic [RowW-1:0]   rd_row_b,
   input  logic [RowW-1:0]   wr_row,
   input  logic [COEF_W-1:0] wr_data,
   output logic [COEF_W-1:0] rd_data_a,
   output logic [COEF_W-1:0] rd_data_b
);

   logic [COEF_W-1:0] mem_ff [NUM_COLS][Rows];
   logic [COEF_W-1:0] rd_data_a_ff;
   logic [COEF_W-1:0] rd_data_b_ff;

   // read data holds while its port is idle
   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         mem_ff[mem_ctl.col_w][wr_row] <= wr_data;
      end
      if (mem_ctl.rd_en_a) begin
         rd_data_a_ff <= mem_ff[mem_ctl.col_a][rd_row_a];
      end
      if (mem_ctl.rd_en_b) begin
         rd_data_b_ff <= mem_ff[mem_ctl.col_b][rd_row_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

### rtl/core/cgen_seq.sv
// -----------------------------------------------------------------------------
// cgen_seq
// Sequencer: seeds T0/T1, runs the recurrence passes over the column memory
// and scans the result column into the response register.
// -----------------------------------------------------------------------------
module cgen_seq import cgen_pkg::*; #(
   parameter int  MAX_DEGREE = MAX_DEGREE_DEF,
   localparam int Rows       = MAX_DEGREE + 1,
   localparam int RowW       = $clog2(Rows)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [DEGREE_W-1:0]      req_degree,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [POWER_W-1:0]       rsp_power,
   output logic signed [COEF_W-1:0] rsp_coefficient,
   output logic                     rsp_last,
   output mem_ctl_type              mem_ctl,
   output logic [RowW-1:0]          rd_row_a,
   output logic [RowW-1:0]          rd_row_b,
   output logic [RowW-1:0]          wr_row,
   output logic [COEF_W-1:0]        wr_data,
   input  logic [COEF_W-1:0]        rd_data_a,
   input  logic [COEF_W-1:0]        rd_data_b
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_INIT  = 5'b00010,
      ST_PASS  = 5'b00100,
      ST_SCAN  = 5'b01000,
      ST_CHECK = 5'b10000
   } seq_state_type;

   seq_state_type     state_ff, state_in;
   logic [RowW-1:0]   n_ff, n_in;
   logic [RowW-1:0]   k_ff, k_in;
   logic [RowW-1:0]   i_ff, i_in;
   col_type           nxt_ff, nxt_in;
   col_type           cur_ff, cur_in;
   col_type           prv_ff, prv_in;

   // write-back stage of the recurrence
   logic              wb_pend_ff, wb_pend_in;
   col_type           wb_col_ff, wb_col_in;
   logic [RowW-1:0]   wb_row_ff, wb_row_in;
   logic              wb_first_ff, wb_first_in;
   logic              wb_prv_ok_ff, wb_prv_ok_in;
   logic [COEF_W-1:0] wb_value;

   // response register
   logic                     out_valid_ff, out_valid_in;
   logic                     out_load;
   logic [POWER_W-1:0]       out_power_ff;
   logic signed [COEF_W-1:0] out_coef_ff;
   logic                     out_last_ff;

   logic              init_we;
   col_type           init_col;
   logic [RowW-1:0]   init_row;
   logic              init_one;
   logic              row_last;

   assign row_last = (i_ff == n_ff);

   // 2x*T(k+1) - T(k), one row
   always_comb begin
      logic [COEF_W-1:0] shifted;
      logic [COEF_W-1:0] sub;
      shifted  = wb_first_ff ? '0 : {rd_data_a[COEF_W-2:0], 1'b0};
      sub      = wb_prv_ok_ff ? rd_data_b : '0;
      wb_value = shifted - sub;
   end

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      k_in         = k_ff;
      i_in         = i_ff;
      nxt_in       = nxt_ff;
      cur_in       = cur_ff;
      prv_in       = prv_ff;
      wb_pend_in   = 1'b0;
      wb_col_in    = wb_col_ff;
      wb_row_in    = wb_row_ff;
      wb_first_in  = wb_first_ff;
      wb_prv_ok_in = wb_prv_ok_ff;
      out_load     = 1'b0;
      mem_ctl      = '0;
      rd_row_a     = '0;
      rd_row_b     = '0;
      init_we      = 1'b0;
      init_col     = cur_ff;
      init_row     = '0;
      init_one     = 1'b0;
      req_ready    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               // saturate the degree
               if (req_degree > DEGREE_W'(MAX_DEGREE)) begin
                  n_in = RowW'(MAX_DEGREE);
               end else begin
                  n_in = RowW'(req_degree);
               end
               nxt_in   = COL_NEXT_RST;
               cur_in   = COL_CUR_RST;
               prv_in   = COL_PREV_RST;
               i_in     = '0;
               state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            // seed previous = 1, current = x
            init_we = 1'b1;
            if (i_ff == '0) begin
               init_col = prv_ff;
               init_one = 1'b1;
               i_in     = i_ff + 1'b1;
            end else if (i_ff == RowW'(1)) begin
               i_in = i_ff + 1'b1;
            end else begin
               init_row = RowW'(1);
               init_one = 1'b1;
               i_in     = '0;
               if (n_ff < RowW'(2)) begin
                  state_in = ST_SCAN;
               end else begin
                  k_in     = RowW'(2);
                  state_in = ST_PASS;
               end
            end
         end
         ST_PASS: begin
            mem_ctl.rd_en_a = 1'b1;
            mem_ctl.rd_en_b = 1'b1;
            mem_ctl.col_a   = cur_ff;
            mem_ctl.col_b   = prv_ff;
            rd_row_a        = (i_ff == '0) ? '0 : i_ff - 1'b1;
            rd_row_b        = i_ff;
            wb_pend_in      = 1'b1;
            wb_col_in       = nxt_ff;
            wb_row_in       = i_ff;
            wb_first_in     = (i_ff == '0);
            // previous column holds rows up to k-2 only
            wb_prv_ok_in    = (i_ff < k_ff - 1'b1);
            if (i_ff == k_ff) begin
               prv_in = cur_ff;
               cur_in = nxt_ff;
               nxt_in = prv_ff;
               i_in   = '0;
               if (k_ff == n_ff) begin
                  state_in = ST_SCAN;
               end else begin
                  k_in = k_ff + 1'b1;
               end
            end else begin
               i_in = i_ff + 1'b1;
            end
         end
         ST_SCAN: begin
            mem_ctl.rd_en_a = 1'b1;
            mem_ctl.col_a   = (n_ff == '0) ? prv_ff : cur_ff;
            rd_row_a        = i_ff;
            state_in        = ST_CHECK;
         end
         ST_CHECK: begin
            if (rd_data_a == '0 || !out_valid_ff || rsp_ready) begin
               out_load = (rd_data_a != '0);
               if (row_last) begin
                  state_in = ST_IDLE;
               end else begin
                  i_in     = i_ff + 1'b1;
                  state_in = ST_SCAN;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      out_valid_in = out_load | (out_valid_ff & ~rsp_ready);

      // single write port: seeding, then recurrence write-back
      mem_ctl.wr_en = init_we | wb_pend_ff;
      mem_ctl.col_w = init_we ? init_col : wb_col_ff;
      wr_row        = init_we ? init_row : wb_row_ff;
      wr_data       = init_we ? COEF_W'(init_one) : wb_value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         nxt_ff       <= COL_NEXT_RST;
         cur_ff       <= COL_CUR_RST;
         prv_ff       <= COL_PREV_RST;
         wb_pend_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
         n_ff         <= '0;
         k_ff         <= '0;
         i_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         nxt_ff       <= nxt_in;
         cur_ff       <= cur_in;
         prv_ff       <= prv_in;
         wb_pend_ff   <= wb_pend_in;
         out_valid_ff <= out_valid_in;
         n_ff         <= n_in;
         k_ff         <= k_in;
         i_ff         <= i_in;
      end
   end

   always_ff @(posedge clock) begin
      wb_col_ff    <= wb_col_in;
      wb_row_ff    <= wb_row_in;
      wb_first_ff  <= wb_first_in;
      wb_prv_ok_ff <= wb_prv_ok_in;
      if (out_load) begin
         out_power_ff <= POWER_W'(i_ff);
         out_coef_ff  <= rd_data_a;
         out_last_ff  <= row_last;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_power       = out_power_ff;
   assign rsp_coefficient = out_coef_ff;
   assign rsp_last        = out_last_ff;

endmodule

### rtl/core/chebyshev_coefficient_generator.sv
// -----------------------------------------------------------------------------
// chebyshev_coefficient_generator
// Builds the power-basis coefficients of T_n and streams the nonzero ones.
// -----------------------------------------------------------------------------
// Sequence: the request is accepted, T0 and T1 are seeded, the recurrence
//   passes run (n >= 2), then each of the n+1 rows is scanned and checked;
//   response stalls hold the scan. Throughput: one item at a time, the
//   single memory write port, one row per cycle, sets the pass length.
// Reset: synchronous, active high; clears the sequencer and response valid.
//   The column memory needs no clearing; every row whose value is used is
//   written first, and unwritten rows of the previous column are masked.
// -----------------------------------------------------------------------------
module chebyshev_coefficient_generator import cgen_pkg::*; #(
   parameter int  MAX_DEGREE = MAX_DEGREE_DEF,
   localparam int Rows       = MAX_DEGREE + 1,
   localparam int RowW       = $clog2(Rows)
) (
   input  logic       clock,
   input  logic       reset,
   cgen_req_if.sink   req_ch,
   cgen_rsp_if.source rsp_ch
);

   // memory request from the sequencer
   mem_ctl_type       mem_ctl;
   logic [RowW-1:0]   rd_row_a;
   logic [RowW-1:0]   rd_row_b;
   logic [RowW-1:0]   wr_row;
   logic [COEF_W-1:0] wr_data;
   logic [COEF_W-1:0] rd_data_a;
   logic [COEF_W-1:0] rd_data_b;

   // Three columns rotate roles each pass: next gets 2x*current - previous,
   // then next becomes current and previous is freed for the following pass.
   cgen_coef_mem #(
      .MAX_DEGREE (MAX_DEGREE)
   ) u_mem (
      .clock     (clock),
      .mem_ctl   (mem_ctl),
      .rd_row_a  (rd_row_a),
      .rd_row_b  (rd_row_b),
      .wr_row    (wr_row),
      .wr_data   (wr_data),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   // Sequencer owns the handshakes; the response register lets the last
   // item of one request wait while the next request is taken.
   cgen_seq #(
      .MAX_DEGREE (MAX_DEGREE)
   ) u_seq (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_ch.valid),
      .req_ready       (req_ch.ready),
      .req_degree      (req_ch.degree),
      .rsp_valid       (rsp_ch.valid),
      .rsp_ready       (rsp_ch.ready),
      .rsp_power       (rsp_ch.power),
      .rsp_coefficient (rsp_ch.coefficient),
      .rsp_last        (rsp_ch.last),
      .mem_ctl         (mem_ctl),
      .rd_row_a        (rd_row_a),
      .rd_row_b        (rd_row_b),
      .wr_row          (wr_row),
      .wr_data         (wr_data),
      .rd_data_a       (rd_data_a),
      .rd_data_b       (rd_data_b)
   );

endmodule

### rtl/core/cgen_checker.sv
// -----------------------------------------------------------------------------
// cgen_checker
// Port-level checks for the Chebyshev coefficient generator.
// -----------------------------------------------------------------------------
module cgen_checker import cgen_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [POWER_W-1:0]       rsp_power,
   input logic signed [COEF_W-1:0] rsp_coefficient,
   input logic                     rsp_last
);

   // a stalled item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_power)
         && $stable(rsp_coefficient) && $stable(rsp_last))
      else $error("response changed while stalled");

   // only nonzero coefficients are emitted
   a_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_coefficient != '0)
      else $error("zero coefficient emitted");

   // leading coefficient is not negative (sign bit clear)
   a_lead_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> !rsp_coefficient[COEF_W-1])
      else $error("negative leading coefficient");

   // one request at a time
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind chebyshev_coefficient_generator cgen_checker u_chk (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_power       (rsp_ch.power),
   .rsp_coefficient (rsp_ch.coefficient),
   .rsp_last        (rsp_ch.last)
);

### dv/tb_chebyshev_coefficient_generator.sv
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// tb_chebyshev_coefficient_generator
// Self-checking bench for the Chebyshev coefficient generator: degrees go in,
// a scoreboard builds T_n by the three-term recurrence at 48 bits and checks
// every streamed (power, coefficient, last) item against it in order.
// -----------------------------------------------------------------------------

// One expected nonzero term of T_n.
typedef struct {
   logic [cgen_pkg::POWER_W-1:0]       power;
   logic signed [cgen_pkg::COEF_W-1:0] coefficient;
   logic                               last;
} coef_term_type;

class coefficient_scoreboard;
   coef_term_type pending_terms[$];
   int            degrees_seen;
   int            results_seen;
   int            mismatches;

   function new();
      degrees_seen = 0;
      results_seen = 0;
      mismatches   = 0;
   endfunction

   // Build T_n from T0 = 1 and T1 = x, then queue its nonzero terms in
   // ascending power order; the term at power n carries last.
   function void note_degree(input logic [cgen_pkg::DEGREE_W-1:0] degree);
      logic [cgen_pkg::COEF_W-1:0] older [cgen_pkg::MAX_DEGREE_DEF+1];
      logic [cgen_pkg::COEF_W-1:0] newer [cgen_pkg::MAX_DEGREE_DEF+1];
      logic [cgen_pkg::COEF_W-1:0] built [cgen_pkg::MAX_DEGREE_DEF+1];
      logic [cgen_pkg::COEF_W-1:0] shifted;
      coef_term_type               term;
      int                          n;
      degrees_seen++;
      n = degree;
      if (n > cgen_pkg::MAX_DEGREE_DEF) begin
         n = cgen_pkg::MAX_DEGREE_DEF;
      end
      for (int i = 0; i <= cgen_pkg::MAX_DEGREE_DEF; i++) begin
         older[i] = '0;
         newer[i] = '0;
      end
      older[0] = 1;
      newer[1] = 1;
      for (int k = 2; k <= n; k++) begin
         for (int i = 0; i <= cgen_pkg::MAX_DEGREE_DEF; i++) begin
            shifted  = (i == 0) ? '0 : (newer[i-1] << 1);
            built[i] = shifted - older[i];
         end
         older = newer;
         newer = built;
      end
      if (n == 0) begin
         newer = older;
      end
      for (int i = 0; i <= n; i++) begin
         if (newer[i] != '0) begin
            term.power       = i[cgen_pkg::POWER_W-1:0];
            term.coefficient = newer[i];
            term.last        = (i == n);
            pending_terms.push_back(term);
         end
      end
   endfunction

   function void check_result(input logic [cgen_pkg::POWER_W-1:0] power,
                              input logic signed [cgen_pkg::COEF_W-1:0] coefficient,
                              input logic last);
      coef_term_type want;
      results_seen++;
      if (pending_terms.size() == 0) begin
         $display("%0t: unexpected result: power %0d coefficient %0d last %0b",
                  $time, power, coefficient, last);
         mismatches++;
         return;
      end
      want = pending_terms.pop_front();
      if (power !== want.power) begin
         $display("%0t: power expected %0d actual %0d", $time, want.power, power);
         mismatches++;
      end
      if (coefficient !== want.coefficient) begin
         $display("%0t: coefficient of x^%0d expected %0d actual %0d",
                  $time, want.power, want.coefficient, coefficient);
         mismatches++;
      end
      if (last !== want.last) begin
         $display("%0t: last at x^%0d expected %0b actual %0b",
                  $time, want.power, want.last, last);
         mismatches++;
      end
   endfunction

   function int pending();
      return pending_terms.size();
   endfunction
endclass

module tb_chebyshev_coefficient_generator;
   import cgen_pkg::*;

   localparam int MaxDegree     = MAX_DEGREE_DEF;
   // Long response hold-off, well past the run of one degree-32 item,
   // so the block fills and stalls its request side.
   localparam int LongHold      = 1500;
   // Cycles without any accepted item before the run is declared hung. The
   // worst legal quiet stretch is the long hold plus one full item.
   localparam int WatchdogLimit = 20000;
   localparam int DrainCycles   = 100;

   logic clock;
   logic reset;

   cgen_req_if req_ch ();
   cgen_rsp_if rsp_ch ();

   chebyshev_coefficient_generator #(
      .MAX_DEGREE(MaxDegree)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   coefficient_scoreboard sb;

   // Idle percentages for each side; the stimulus process moves them between
   // phases, the driver and the response process read them.
   int tx_idle_pct;
   int rx_idle_pct;
   bit hold_request;
   bit hold_taken;
   int hold_left;
   int quiet_cycles = 0;
   bit long_hold_done;

   initial begin
      clock = 1'b0;
   end

   always begin
      #5 clock = ~clock;
   end

   // Response side: hold ready low for the long stretch when asked, else
   // drop it at random with the current idle percentage.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         hold_left = 0;
      end else if (hold_left > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left = hold_left - 1;
         if (hold_left == 0) begin
            long_hold_done = 1'b1;
         end
      end else if (hold_request && !hold_taken) begin
         hold_taken   = 1'b1;
         hold_left    = LongHold;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // Monitor both channels on the same edge: note the request first so a
   // fast response can never overtake its own expectation.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            sb.note_degree(req_ch.degree);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            sb.check_result(rsp_ch.power, rsp_ch.coefficient, rsp_ch.last);
         end
      end
   end

   // Watchdog: count cycles in which neither channel moves an item.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WatchdogLimit) begin
         $display("%0t: no item moved for %0d cycles, %0d results still expected",
                  $time, quiet_cycles, sb.pending());
         $display("Mismatches found");
         $finish;
      end
   end

   // Offer one degree: idle a random number of cycles first (valid low), then
   // hold valid until the block takes the item. Valid stays high into the
   // next call when no gap follows.
   task automatic send_degree(input logic [DEGREE_W-1:0] degree);
      int gap;
      gap = 0;
      while (gap < 40 && $urandom_range(99) < tx_idle_pct) begin
         gap++;
      end
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.degree <= degree;
      @(posedge clock);
      while (!req_ch.ready) begin
         @(posedge clock);
      end
   endtask

   // Mostly legal degrees, with a share above the maximum to hit saturation
   // and the upper bit of the field.
   task automatic send_random(input int count);
      logic [DEGREE_W-1:0] degree;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99) < 70) begin
            degree = DEGREE_W'($urandom_range(MaxDegree));
         end else begin
            degree = DEGREE_W'($urandom_range(63, MaxDegree + 1));
         end
         send_degree(degree);
      end
   endtask

   initial begin
      logic [DEGREE_W-1:0] directed_degrees [$];
      sb             = new();
      reset          = 1'b1;
      req_ch.valid  <= 1'b0;
      req_ch.degree <= '0;
      hold_request   = 1'b0;
      tx_idle_pct    = 17;
      rx_idle_pct    = 61;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: the seed degrees 0 and 1, T2 = 2x^2 - 1, small odd and
      // even cases, the maximum, one past it, the all-ones field value and
      // alternating bit patterns.
      directed_degrees = '{6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd8, 6'd16,
                           6'd31, 6'd32, 6'd33, 6'd36, 6'd63, 6'd42, 6'd21,
                           6'd62, 6'd30};
      foreach (directed_degrees[i]) begin
         send_degree(directed_degrees[i]);
      end

      // Phase one: sender idles lightly, receiver heavily.
      send_random(70);

      // Phase two: swap the idle profiles.
      tx_idle_pct = 61;
      rx_idle_pct = 17;
      send_random(70);

      // Phase three: no idling on either side, opened by one long receiver
      // hold-off while requests keep coming.
      tx_idle_pct  = 0;
      rx_idle_pct  = 0;
      hold_request = 1'b1;
      send_random(75);

      req_ch.valid <= 1'b0;

      // Drain: wait out every expected term, then let the block settle.
      while (sb.pending() != 0) begin
         @(posedge clock);
      end
      repeat (DrainCycles) @(posedge clock);

      $display("Checked %0d degree requests (0..63, saturating above %0d) and %0d terms",
               sb.degrees_seen, MaxDegree, sb.results_seen);
      $display("under three idle profiles; long response hold-off done: %0b",
               long_hold_done);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("%0d mismatches, %0d terms never arrived", sb.mismatches, sb.pending());
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/core/cgen_pkg.sv
rtl/core/cgen_chan_if.sv
rtl/core/cgen_coef_mem.sv
rtl/core/cgen_seq.sv
rtl/core/chebyshev_coefficient_generator.sv
rtl/core/cgen_checker.sv
dv/tb_chebyshev_coefficient_generator.sv
